FILE: rtl/msgr_pkg.sv
// ----------------------------------------------------------------------------
// msgr_pkg
// Shared constants, types and helpers for the multi-stop gradient ramp.
// ----------------------------------------------------------------------------
`default_nettype none

package msgr_pkg;

  // Configuration port
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STOPS = 3'd7;

  // Stop slots and default stop count limit
  localparam int MAX_STOPS_DEF = 7;
  localparam int NST_W         = 3;
  localparam logic [NST_W-1:0] NST_MIN = 3'd2;

  // Reset values of the stop registers
  localparam logic [CFG_W-1:0] STOP_RST     = 32'h0000_0000;
  localparam logic [CFG_W-1:0] STOP_END_RST = 32'hFFFF_FFFF;

  // Field widths
  localparam int IDX_W  = 8;
  localparam int LEN_W  = 9;
  localparam int CH_W   = 8;
  localparam int POS_W  = 8;
  localparam int NCHAN  = 3;
  localparam logic [POS_W-1:0] POS_MAX = 8'd255;

  // Divider widths: index*255 and |p-p0|*256 both fit in 16 bits
  localparam int DIVN_W = 16;

  // Depth of the request queue between front and back
  localparam int QDEPTH = 2;

  typedef logic [CFG_W-1:0] stop_word_t;

  // Request passed from the front to the back
  typedef struct packed {
    logic [POS_W-1:0] pos;
    stop_word_t       w0;
    stop_word_t       w1;
  } seg_req_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_SEARCH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_MUL,
    B_OUT
  } back_state_t;

  // Stop position byte
  function automatic logic [POS_W-1:0] pos_of(input stop_word_t w);
    pos_of = w[31:24];
  endfunction

  // Color byte: channel 0 red, 1 green, 2 blue
  function automatic logic [CH_W-1:0] chan_of(input stop_word_t w, input int c);
    chan_of = w[23 - 8*c -: 8];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/msgr_div.sv
// ----------------------------------------------------------------------------
// msgr_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module msgr_div #(
  parameter int NW = 16,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic               done,
  output logic [NW-1:0]      quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    den_r, den_nxt;
  logic [NW-1:0]    quo_r, quo_nxt;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             ge;

  // One shift-subtract step
  always_comb begin
    trial = {rem_r, quo_r[NW-1]};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NW);
      rem_nxt  = '0;
      den_nxt  = den;
      quo_nxt  = num;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

  // done only follows the last iteration
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

endmodule

`default_nettype wire

FILE: rtl/msgr_front.sv
// ----------------------------------------------------------------------------
// msgr_front
// Accepts requests, maps the index to a ramp position and finds the segment.
// ----------------------------------------------------------------------------
`default_nettype none

module msgr_front #(
  parameter int MAX_STOPS = msgr_pkg::MAX_STOPS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    push,
  output logic                                         full,
  input  wire logic [msgr_pkg::IDX_W-1:0]              entry_index,
  input  wire logic [msgr_pkg::LEN_W-1:0]              ramp_length,
  input  wire logic [MAX_STOPS-1:0][msgr_pkg::CFG_W-1:0] stops,
  input  wire logic [msgr_pkg::NST_W-1:0]              nst,
  output logic                                         q_push,
  output msgr_pkg::seg_req_t                           q_data,
  input  wire logic                                    q_full
);

  localparam int STOP_W = $clog2(MAX_STOPS);

  msgr_pkg::front_state_t state_r, state_nxt;

  logic [msgr_pkg::POS_W-1:0]  p_r;
  msgr_pkg::stop_word_t        cur_r, nxt_r;
  logic [STOP_W-1:0]           k_r;
  logic [STOP_W-1:0]           rd_idx;
  msgr_pkg::stop_word_t        rd_word;
  logic [msgr_pkg::NST_W-1:0]  last_idx;
  logic                        adv;
  logic                        long_ramp;
  logic                        div_start;
  logic                        div_busy, div_done;
  logic [msgr_pkg::DIVN_W-1:0] div_num, div_quo;
  logic [msgr_pkg::LEN_W-1:0]  div_den;
  logic [msgr_pkg::POS_W-1:0]  p_sat;

  // Position divider: index*255 / (length-1)
  always_comb begin
    long_ramp = ramp_length > msgr_pkg::LEN_W'(1);
    div_num   = {entry_index, 8'h00} - {8'h00, entry_index};
    div_den   = ramp_length - msgr_pkg::LEN_W'(1);
    p_sat     = (div_quo > msgr_pkg::DIVN_W'(msgr_pkg::POS_MAX)) ? msgr_pkg::POS_MAX
                                                                : div_quo[7:0];
  end

  msgr_div #(
    .NW (msgr_pkg::DIVN_W),
    .DW (msgr_pkg::LEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Segment walk: k_r is the index of the upper stop of the segment
  always_comb begin
    last_idx = nst - msgr_pkg::NST_W'(1);
    rd_idx   = k_r + STOP_W'(1);
    rd_word  = (int'(rd_idx) < MAX_STOPS) ? stops[rd_idx] : '0;
    adv      = (msgr_pkg::NST_W'(k_r) < last_idx) && (p_r > msgr_pkg::pos_of(nxt_r));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      msgr_pkg::F_IDLE: begin
        if (push) begin
          state_nxt = long_ramp ? msgr_pkg::F_DIV : msgr_pkg::F_SEARCH;
        end
      end
      msgr_pkg::F_DIV: begin
        if (div_done) begin
          state_nxt = msgr_pkg::F_SEARCH;
        end
      end
      msgr_pkg::F_SEARCH: begin
        if (!adv && !q_full) begin
          state_nxt = msgr_pkg::F_IDLE;
        end
      end
      default: state_nxt = msgr_pkg::F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    full      = (state_r != msgr_pkg::F_IDLE);
    div_start = (state_r == msgr_pkg::F_IDLE) && push && long_ramp;
    q_push    = (state_r == msgr_pkg::F_SEARCH) && !adv && !q_full;
    q_data.pos = p_r;
    q_data.w0  = cur_r;
    q_data.w1  = nxt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msgr_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == msgr_pkg::F_IDLE && push) begin
      p_r   <= '0;
      cur_r <= stops[0];
      nxt_r <= stops[1];
      k_r   <= STOP_W'(1);
    end else if (state_r == msgr_pkg::F_DIV && div_done) begin
      p_r <= p_sat;
    end else if (state_r == msgr_pkg::F_SEARCH && adv) begin
      cur_r <= nxt_r;
      nxt_r <= rd_word;
      k_r   <= rd_idx;
    end
  end

  // Walk never passes the last stop in use
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msgr_pkg::F_SEARCH) |-> (msgr_pkg::NST_W'(k_r) <= last_idx))
    else $error("segment walk beyond last stop");

  // Waiting on the divider only while it runs or reports
  a_div_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msgr_pkg::F_DIV) |-> (div_busy || div_done))
    else $error("front waits on an idle divider");

endmodule

`default_nettype wire

FILE: rtl/msgr_fifo.sv
// ----------------------------------------------------------------------------
// msgr_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module msgr_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire msgr_pkg::seg_req_t wr_data,
  output logic                    full,
  input  wire logic               rd_en,
  output msgr_pkg::seg_req_t      rd_data,
  output logic                    empty
);

  localparam int PTR_W = (msgr_pkg::QDEPTH > 1) ? $clog2(msgr_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(msgr_pkg::QDEPTH + 1);

  msgr_pkg::seg_req_t entries_r [msgr_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  // Pointer and count update
  always_comb begin
    full    = (cnt_r == CNT_W'(msgr_pkg::QDEPTH));
    empty   = (cnt_r == '0);
    do_wr   = wr_en && !full;
    do_rd   = rd_en && !empty;
    rd_data = entries_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == msgr_pkg::QDEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == msgr_pkg::QDEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + CNT_W'(do_wr) - CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_wr) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(msgr_pkg::QDEPTH))
    else $error("request queue overflow");

endmodule

`default_nettype wire

FILE: rtl/msgr_back.sv
// ----------------------------------------------------------------------------
// msgr_back
// Computes the fraction within the segment and blends the three channels.
// ----------------------------------------------------------------------------
`default_nettype none

module msgr_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  wire msgr_pkg::seg_req_t          q_data,
  output logic                             q_pop,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [msgr_pkg::CH_W-1:0]        red,
  output logic [msgr_pkg::CH_W-1:0]        green,
  output logic [msgr_pkg::CH_W-1:0]        blue
);

  localparam int T_W    = msgr_pkg::DIVN_W + 1;
  localparam int D_W    = msgr_pkg::CH_W + 1;
  localparam int PROD_W = T_W + D_W;

  msgr_pkg::back_state_t state_r, state_nxt;

  msgr_pkg::stop_word_t        w0_r, w1_r;
  logic                        neg_r;
  logic signed [T_W-1:0]       t_r;
  logic signed [PROD_W-1:0]    prod_r [msgr_pkg::NCHAN];
  logic signed [PROD_W-1:0]    prod_nxt [msgr_pkg::NCHAN];
  logic signed [D_W-1:0]       delta [msgr_pkg::NCHAN];
  logic [PROD_W-1:0]           adj [msgr_pkg::NCHAN];
  logic [msgr_pkg::CH_W-1:0]   res [msgr_pkg::NCHAN];
  logic [msgr_pkg::CH_W-1:0]   out_r [msgr_pkg::NCHAN];
  logic                        out_valid_r, out_valid_nxt;
  logic [msgr_pkg::POS_W-1:0]  p0, p1;
  logic [msgr_pkg::POS_W:0]    dpos;
  logic [msgr_pkg::POS_W-1:0]  dmag;
  logic                        seg_open;
  logic                        take;
  logic                        load_out;
  logic                        div_start, div_busy, div_done;
  logic [msgr_pkg::DIVN_W-1:0] div_num, div_quo;
  logic [msgr_pkg::POS_W-1:0]  div_den;
  logic [T_W-1:0]              t_div;

  // Fraction setup from the incoming request
  always_comb begin
    p0       = msgr_pkg::pos_of(q_data.w0);
    p1       = msgr_pkg::pos_of(q_data.w1);
    dpos     = {1'b0, q_data.pos} - {1'b0, p0};
    dmag     = dpos[msgr_pkg::POS_W] ? msgr_pkg::POS_W'(-dpos) : dpos[msgr_pkg::POS_W-1:0];
    seg_open = p1 > p0;
    div_num  = {dmag, 8'h00};
    div_den  = p1 - p0;
    t_div    = neg_r ? T_W'(-{1'b0, div_quo}) : {1'b0, div_quo};
  end

  // Fraction divider: |pos - p0| * 256 / (p1 - p0)
  msgr_div #(
    .NW (msgr_pkg::DIVN_W),
    .DW (msgr_pkg::POS_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Channel products and final blend
  always_comb begin
    for (int c = 0; c < msgr_pkg::NCHAN; c++) begin
      delta[c] = $signed({1'b0, msgr_pkg::chan_of(w1_r, c)})
               - $signed({1'b0, msgr_pkg::chan_of(w0_r, c)});
      prod_nxt[c] = delta[c] * t_r;
      // divide by 256 truncating toward zero
      adj[c] = prod_r[c] + (prod_r[c][PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
      res[c] = msgr_pkg::chan_of(w0_r, c) + adj[c][15:8];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      msgr_pkg::B_IDLE: begin
        if (!q_empty) begin
          state_nxt = seg_open ? msgr_pkg::B_DIV : msgr_pkg::B_MUL;
        end
      end
      msgr_pkg::B_DIV: begin
        if (div_done) begin
          state_nxt = msgr_pkg::B_MUL;
        end
      end
      msgr_pkg::B_MUL: state_nxt = msgr_pkg::B_OUT;
      msgr_pkg::B_OUT: begin
        if (!out_valid_r || pop) begin
          state_nxt = msgr_pkg::B_IDLE;
        end
      end
      default: state_nxt = msgr_pkg::B_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    take      = (state_r == msgr_pkg::B_IDLE) && !q_empty;
    q_pop     = take;
    div_start = take && seg_open;
    load_out  = (state_r == msgr_pkg::B_OUT) && (!out_valid_r || pop);
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
    empty = !out_valid_r;
    red   = out_r[0];
    green = out_r[1];
    blue  = out_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msgr_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (take) begin
      w0_r  <= q_data.w0;
      w1_r  <= q_data.w1;
      neg_r <= dpos[msgr_pkg::POS_W];
      t_r   <= '0;
    end else if (state_r == msgr_pkg::B_DIV && div_done) begin
      t_r <= t_div;
    end
    if (state_r == msgr_pkg::B_MUL) begin
      for (int c = 0; c < msgr_pkg::NCHAN; c++) begin
        prod_r[c] <= prod_nxt[c];
      end
    end
    if (load_out) begin
      for (int c = 0; c < msgr_pkg::NCHAN; c++) begin
        out_r[c] <= res[c];
      end
    end
  end

  a_div_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msgr_pkg::B_DIV) |-> (div_busy || div_done))
    else $error("back waits on an idle divider");

endmodule

`default_nettype wire

FILE: rtl/multi_stop_gradient_ramp.sv
// ----------------------------------------------------------------------------
// multi_stop_gradient_ramp
// Piecewise-linear RGB ramp generator, one palette entry per request.
// ----------------------------------------------------------------------------
// Each request gives an entry index and a ramp length; the block maps the
// index to a position 0..255, finds the stop segment holding it and returns
// the interpolated red, green and blue. A front stage runs the position
// division (one quotient bit per cycle) and walks the stops one segment per
// cycle; a back stage runs the fraction division and the channel
// multiplies. A two-entry queue sits between them and a result register at
// the output, so the two stages overlap. The position division is skipped
// for a length of 0 or 1, and the fraction division for an empty segment.
// The front takes a new request only once it has passed the last one to
// the queue, the back only once its result is in the output register, and
// the slower of the two sets the steady rate. The user must write the stop
// registers only while the block is idle; the block does not enforce this.
`default_nettype none

module multi_stop_gradient_ramp #(
  parameter int MAX_STOPS = msgr_pkg::MAX_STOPS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request side
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [msgr_pkg::IDX_W-1:0]      in_entry_index,
  input  wire logic [msgr_pkg::LEN_W-1:0]      in_ramp_length,
  // result side
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [msgr_pkg::CH_W-1:0]            out_red,
  output logic [msgr_pkg::CH_W-1:0]            out_green,
  output logic [msgr_pkg::CH_W-1:0]            out_blue,
  // configuration
  input  wire logic                            cfg_wr_en,
  input  wire logic [msgr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [msgr_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int STOP_W = $clog2(MAX_STOPS);

  logic [MAX_STOPS-1:0][msgr_pkg::CFG_W-1:0] stops_r;
  logic [msgr_pkg::NST_W-1:0]                num_stops_r;
  logic [msgr_pkg::NST_W-1:0]                nst;
  logic                                      q_push, q_full, q_pop, q_empty;
  msgr_pkg::seg_req_t                        q_wdata, q_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_STOPS; i++) begin
        stops_r[i] <= (i == 1) ? msgr_pkg::STOP_END_RST : msgr_pkg::STOP_RST;
      end
      num_stops_r <= msgr_pkg::NST_MIN;
    end else if (cfg_wr_en) begin
      if (cfg_index == msgr_pkg::CFG_NUM_STOPS) begin
        num_stops_r <= cfg_wdata[msgr_pkg::NST_W-1:0];
      end else if (int'(cfg_index) < MAX_STOPS) begin
        stops_r[cfg_index[STOP_W-1:0]] <= cfg_wdata;
      end
    end
  end

  // Clamp the stop count to the supported range
  always_comb begin
    if (num_stops_r < msgr_pkg::NST_MIN) begin
      nst = msgr_pkg::NST_MIN;
    end else if (num_stops_r > msgr_pkg::NST_W'(MAX_STOPS)) begin
      nst = msgr_pkg::NST_W'(MAX_STOPS);
    end else begin
      nst = num_stops_r;
    end
  end

  msgr_front #(
    .MAX_STOPS (MAX_STOPS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .entry_index (in_entry_index),
    .ramp_length (in_ramp_length),
    .stops       (stops_r),
    .nst         (nst),
    .q_push      (q_push),
    .q_data      (q_wdata),
    .q_full      (q_full)
  );

  msgr_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  msgr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .red     (out_red),
    .green   (out_green),
    .blue    (out_blue)
  );

endmodule

`default_nettype wire
